// File: hw/rtl/chsr_pkg.sv
// chsr_pkg: types, codes and constants shared by the shard router modules.
// Depends on nothing; every other file but chsr_ram refers to it by scoped names.
`timescale 1ns / 1ps

package chsr_pkg;

    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;
    localparam logic [8:0]  RESET_VNODES = 9'd150;
    localparam logic [31:0] RESET_MODULO = 32'd8;

    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_REMOVE    = 3'd1;
    localparam logic [2:0] CMD_SET_STATE = 3'd2;
    localparam logic [2:0] CMD_VECTOR    = 3'd3;
    localparam logic [2:0] CMD_KEY_BYTE  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] REG_USE_MODULO    = 2'd0;
    localparam logic [1:0] REG_MODULO_SHARDS = 2'd1;
    localparam logic [1:0] REG_VNODES        = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_SET_STATE = 3'd2,
        OP_VECTOR    = 3'd3,
        OP_KEY       = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] shard_ident;
        logic        go_offline;
        logic [63:0] vector_ident;
        logic [7:0]  key_byte;
        logic        key_last;
    } item_t;

    typedef struct packed {
        logic        use_modulo;
        logic [31:0] modulo_shards;
        logic [8:0]  vnodes_per_shard;
    } cfg_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// File: hw/rtl/chsr_ram.sv
// chsr_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module chsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: hw/rtl/chsr_front.sv
// chsr_front: accepts input words, drops unknown commands, queues decoded items.
// Depends on chsr_pkg.
`timescale 1ns / 1ps

module chsr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [31:0]        shard_ident,
    input  logic               go_offline,
    input  logic [63:0]        vector_ident,
    input  logic [7:0]         key_byte,
    input  logic               key_last,
    output chsr_pkg::item_t    q_item,
    output logic               q_valid,
    input  logic               q_pop
);

    chsr_pkg::item_t q_mem_reg [0:1];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    chsr_pkg::item_t dec_item;
    logic            keep;
    logic            push;
    logic            pop;

    always_comb
    begin
        dec_item.op           = chsr_pkg::OP_ADD;
        dec_item.shard_ident  = shard_ident;
        dec_item.go_offline   = go_offline;
        dec_item.vector_ident = vector_ident;
        dec_item.key_byte     = key_byte;
        dec_item.key_last     = key_last;
        keep = 1'b1;
        case (command)
            chsr_pkg::CMD_ADD:       dec_item.op = chsr_pkg::OP_ADD;
            chsr_pkg::CMD_REMOVE:    dec_item.op = chsr_pkg::OP_REMOVE;
            chsr_pkg::CMD_SET_STATE: dec_item.op = chsr_pkg::OP_SET_STATE;
            chsr_pkg::CMD_VECTOR:    dec_item.op = chsr_pkg::OP_VECTOR;
            chsr_pkg::CMD_KEY_BYTE:  dec_item.op = chsr_pkg::OP_KEY;
            default:                 keep = 1'b0;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall && keep;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/chsr_back.sv
// chsr_back: sequencer that runs table changes, ring rebuild (generate, merge sort),
// ring binary search, modulo divider and key and vector hashing. Depends on chsr_pkg, chsr_ram.
`timescale 1ns / 1ps

module chsr_back #(
    parameter int MAX_SHARD_ENTRIES = 64,
    parameter int MAX_VNODES        = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  chsr_pkg::item_t q_item,
    input  logic            q_valid,
    output logic            q_pop,
    input  chsr_pkg::cfg_t  cfg,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [31:0]     routed_shard
);

    localparam int RING_CAP = MAX_SHARD_ENTRIES * MAX_VNODES;
    localparam int AW       = (RING_CAP > 1) ? $clog2(RING_CAP) : 1;
    localparam int LEN_W    = $clog2(RING_CAP + 1);
    localparam int XW       = LEN_W + 2;
    localparam int SIW      = (MAX_SHARD_ENTRIES > 1) ? $clog2(MAX_SHARD_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_SHARD_ENTRIES + 1);
    localparam int VN_W     = $clog2(MAX_VNODES + 1);

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_FIND_RD   = 20'h00002,
        S_FIND_CMP  = 20'h00004,
        S_SHIFT_RD  = 20'h00008,
        S_SHIFT_WR  = 20'h00010,
        S_GEN_RD    = 20'h00020,
        S_GEN_CHK   = 20'h00040,
        S_GEN_HASH  = 20'h00080,
        S_GEN_WR    = 20'h00100,
        S_SORT_PASS = 20'h00200,
        S_RUN       = 20'h00400,
        S_MRG_L     = 20'h00800,
        S_MRG_R     = 20'h01000,
        S_MRG_W     = 20'h02000,
        S_VHASH     = 20'h04000,
        S_DIV       = 20'h08000,
        S_SRCH      = 20'h10000,
        S_SRCH_CMP  = 20'h20000,
        S_SRCH_OUT  = 20'h40000,
        S_DONE      = 20'h80000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ring_sel_reg, ring_sel_next;
    logic [31:0]       acc_reg, acc_next;
    chsr_pkg::op_t     op_reg, op_next;
    logic [31:0]       id_reg, id_next;
    logic              off_reg, off_next;
    logic [63:0]       vec_reg, vec_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [VN_W-1:0]   v_reg, v_next;
    logic [2:0]        k_reg, k_next;
    logic [31:0]       h_reg, h_next;
    logic [31:0]       gid_reg, gid_next;
    logic [LEN_W:0]    w_reg, w_next;
    logic [LEN_W-1:0]  base_reg, base_next;
    logic [LEN_W-1:0]  li_reg, li_next;
    logic [LEN_W-1:0]  ri_reg, ri_next;
    logic [LEN_W-1:0]  le_reg, le_next;
    logic [LEN_W-1:0]  re_reg, re_next;
    logic [LEN_W-1:0]  kk_reg, kk_next;
    logic              src_reg, src_next;
    logic [63:0]       lval_reg, lval_next;
    logic [LEN_W-1:0]  lo_reg, lo_next;
    logic [LEN_W-1:0]  hi_reg, hi_next;
    logic [LEN_W-1:0]  mid_reg, mid_next;
    logic [31:0]       rem_reg, rem_next;
    logic [63:0]       dvd_reg, dvd_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [1:0]        stat_reg, stat_next;
    logic [31:0]       route_reg, route_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [31:0]       out_route_reg, out_route_next;

    // shard table port
    logic              tw_en;
    logic [SIW-1:0]    tw_addr;
    logic [32:0]       tw_data;
    logic [SIW-1:0]    tr_addr;
    logic [32:0]       tr_data;

    // ring ports
    logic              r0_we, r1_we;
    logic [AW-1:0]     r_waddr;
    logic [63:0]       r_wdata;
    logic [AW-1:0]     r_raddr;
    logic [63:0]       r0_rdata, r1_rdata, ring_rdata;

    logic [VN_W-1:0]   vn_eff;
    logic [63:0]       hword;
    logic [7:0]        hbyte;
    logic [31:0]       hstep;
    logic [XW-1:0]     run_mid, run_end, bw, b2w, len_x;
    logic [LEN_W:0]    mid_sum;
    logic [32:0]       div_r1, div_r2;
    logic              take_l;
    logic [63:0]       mval;

    chsr_ram #(.WIDTH(33), .DEPTH(MAX_SHARD_ENTRIES)) u_table (
        .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
        .raddr(tr_addr), .rdata(tr_data)
    );

    chsr_ram #(.WIDTH(64), .DEPTH(RING_CAP)) u_ring0 (
        .clk(clk), .we(r0_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r0_rdata)
    );

    chsr_ram #(.WIDTH(64), .DEPTH(RING_CAP)) u_ring1 (
        .clk(clk), .we(r1_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r1_rdata)
    );

    always_comb
    begin
        if (32'(cfg.vnodes_per_shard) > 32'(MAX_VNODES))
        begin
            vn_eff = VN_W'(MAX_VNODES);
        end
        else
        begin
            vn_eff = VN_W'(cfg.vnodes_per_shard);
        end
    end

    // merge reads the source buffer, search reads the live ring
    assign ring_rdata = ((state_reg == S_MRG_R) || (state_reg == S_MRG_W))
                        ? (src_reg ? r1_rdata : r0_rdata)
                        : (ring_sel_reg ? r1_rdata : r0_rdata);

    assign hword = (state_reg == S_VHASH) ? vec_reg : {gid_reg, 32'(v_reg)};
    assign hbyte = hword[{k_reg, 3'b000} +: 8];
    assign hstep = chsr_pkg::fnv_step(h_reg, hbyte);

    assign len_x   = XW'(len_reg);
    assign bw      = XW'(base_reg) + XW'(w_reg);
    assign b2w     = bw + XW'(w_reg);
    assign run_mid = (bw > len_x) ? len_x : bw;
    assign run_end = (b2w > len_x) ? len_x : b2w;
    assign mid_sum = ((LEN_W + 1)'(lo_reg) + (LEN_W + 1)'(hi_reg)) >> 1;

    assign div_r1 = {rem_reg, dvd_reg[63]};
    assign div_r2 = (div_r1 >= {1'b0, cfg.modulo_shards})
                    ? (div_r1 - {1'b0, cfg.modulo_shards}) : div_r1;

    assign take_l = (li_reg < le_reg) && ((ri_reg >= re_reg) || (lval_reg <= ring_rdata));
    assign mval   = take_l ? lval_reg : ring_rdata;

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign routed_shard = out_route_reg;

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        len_next        = len_reg;
        ring_sel_next   = ring_sel_reg;
        acc_next        = acc_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        off_next        = off_reg;
        vec_next        = vec_reg;
        i_next          = i_reg;
        n_next          = n_reg;
        v_next          = v_reg;
        k_next          = k_reg;
        h_next          = h_reg;
        gid_next        = gid_reg;
        w_next          = w_reg;
        base_next       = base_reg;
        li_next         = li_reg;
        ri_next         = ri_reg;
        le_next         = le_reg;
        re_next         = re_reg;
        kk_next         = kk_reg;
        src_next        = src_reg;
        lval_next       = lval_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        cnt_next        = cnt_reg;
        stat_next       = stat_reg;
        route_next      = route_reg;
        out_valid_next  = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        out_status_next = out_status_reg;
        out_route_next  = out_route_reg;

        tw_en   = 1'b0;
        tw_addr = SIW'(i_reg);
        tw_data = {1'b0, id_reg};
        tr_addr = SIW'(i_reg);
        r0_we   = 1'b0;
        r1_we   = 1'b0;
        r_waddr = AW'(n_reg);
        r_wdata = {h_reg, gid_reg};
        r_raddr = AW'(li_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_item.op;
                    id_next    = q_item.shard_ident;
                    off_next   = q_item.go_offline;
                    vec_next   = q_item.vector_ident;
                    stat_next  = chsr_pkg::ST_OK;
                    route_next = 32'd0;
                    i_next     = '0;
                    k_next     = 3'd0;
                    h_next     = chsr_pkg::FNV_BASIS;
                    case (q_item.op)
                        chsr_pkg::OP_ADD,
                        chsr_pkg::OP_REMOVE,
                        chsr_pkg::OP_SET_STATE:
                        begin
                            state_next = S_FIND_RD;
                        end
                        chsr_pkg::OP_VECTOR:
                        begin
                            if (!cfg.use_modulo)
                            begin
                                state_next = S_VHASH;
                            end
                            else if (cfg.modulo_shards == 32'd0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rem_next   = 32'd0;
                                dvd_next   = q_item.vector_ident;
                                cnt_next   = 6'd0;
                                state_next = S_DIV;
                            end
                        end
                        chsr_pkg::OP_KEY:
                        begin
                            if (q_item.key_last)
                            begin
                                h_next     = chsr_pkg::fnv_step(acc_reg, q_item.key_byte);
                                acc_next   = chsr_pkg::FNV_BASIS;
                                lo_next    = '0;
                                hi_next    = len_reg;
                                state_next = S_SRCH;
                            end
                            else
                            begin
                                acc_next = chsr_pkg::fnv_step(acc_reg, q_item.key_byte);
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND_RD:
            begin
                if (i_reg == held_reg)
                begin
                    if (op_reg == chsr_pkg::OP_ADD)
                    begin
                        if (held_reg == CNT_W'(MAX_SHARD_ENTRIES))
                        begin
                            stat_next  = chsr_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            tw_en      = 1'b1;
                            tw_addr    = SIW'(held_reg);
                            tw_data    = {1'b0, id_reg};
                            held_next  = held_reg + 1'b1;
                            i_next     = '0;
                            n_next     = '0;
                            state_next = S_GEN_RD;
                        end
                    end
                    else
                    begin
                        stat_next  = chsr_pkg::ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    tr_addr    = SIW'(i_reg);
                    state_next = S_FIND_CMP;
                end
            end

            S_FIND_CMP:
            begin
                if (tr_data[31:0] == id_reg)
                begin
                    case (op_reg)
                        chsr_pkg::OP_ADD:
                        begin
                            stat_next  = chsr_pkg::ST_DUPLICATE;
                            state_next = S_DONE;
                        end
                        chsr_pkg::OP_REMOVE:
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        default:
                        begin
                            tw_en      = 1'b1;
                            tw_addr    = SIW'(i_reg);
                            tw_data    = {off_reg, id_reg};
                            i_next     = '0;
                            n_next     = '0;
                            state_next = S_GEN_RD;
                        end
                    endcase
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (((CNT_W + 1)'(i_reg) + 1'b1) < (CNT_W + 1)'(held_reg))
                begin
                    tr_addr    = SIW'(i_reg + 1'b1);
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    held_next  = held_reg - 1'b1;
                    i_next     = '0;
                    n_next     = '0;
                    state_next = S_GEN_RD;
                end
            end

            S_SHIFT_WR:
            begin
                tw_en      = 1'b1;
                tw_addr    = SIW'(i_reg);
                tw_data    = tr_data;
                i_next     = i_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end

            S_GEN_RD:
            begin
                if (i_reg == held_reg)
                begin
                    len_next = n_reg;
                    if (n_reg > LEN_W'(1))
                    begin
                        w_next     = (LEN_W + 1)'(1);
                        src_next   = 1'b0;
                        state_next = S_SORT_PASS;
                    end
                    else
                    begin
                        ring_sel_next = 1'b0;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    tr_addr    = SIW'(i_reg);
                    state_next = S_GEN_CHK;
                end
            end

            S_GEN_CHK:
            begin
                if (tr_data[32] || (vn_eff == '0))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_GEN_RD;
                end
                else
                begin
                    gid_next   = tr_data[31:0];
                    v_next     = '0;
                    k_next     = 3'd0;
                    h_next     = chsr_pkg::FNV_BASIS;
                    state_next = S_GEN_HASH;
                end
            end

            S_GEN_HASH:
            begin
                h_next = hstep;
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    state_next = S_GEN_WR;
                end
            end

            S_GEN_WR:
            begin
                r0_we   = 1'b1;
                r_waddr = AW'(n_reg);
                r_wdata = {h_reg, gid_reg};
                n_next  = n_reg + 1'b1;
                h_next  = chsr_pkg::FNV_BASIS;
                k_next  = 3'd0;
                if (((VN_W + 1)'(v_reg) + 1'b1) == (VN_W + 1)'(vn_eff))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_GEN_RD;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_GEN_HASH;
                end
            end

            S_SORT_PASS:
            begin
                if (XW'(w_reg) >= len_x)
                begin
                    ring_sel_next = src_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    base_next  = '0;
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                li_next    = base_reg;
                ri_next    = LEN_W'(run_mid);
                le_next    = LEN_W'(run_mid);
                re_next    = LEN_W'(run_end);
                kk_next    = base_reg;
                state_next = S_MRG_L;
            end

            S_MRG_L:
            begin
                r_raddr    = AW'(li_reg);
                state_next = S_MRG_R;
            end

            S_MRG_R:
            begin
                r_raddr    = AW'(ri_reg);
                lval_next  = ring_rdata;
                state_next = S_MRG_W;
            end

            S_MRG_W:
            begin
                r_waddr = AW'(kk_reg);
                r_wdata = mval;
                r0_we   = src_reg;
                r1_we   = !src_reg;
                if (take_l)
                begin
                    li_next = li_reg + 1'b1;
                end
                else
                begin
                    ri_next = ri_reg + 1'b1;
                end
                kk_next = kk_reg + 1'b1;
                if ((kk_reg + 1'b1) == re_reg)
                begin
                    base_next = re_reg;
                    if (re_reg >= len_reg)
                    begin
                        w_next     = w_reg << 1;
                        src_next   = !src_reg;
                        state_next = S_SORT_PASS;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
                else
                begin
                    state_next = S_MRG_L;
                end
            end

            S_VHASH:
            begin
                h_next = hstep;
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    lo_next    = '0;
                    hi_next    = len_reg;
                    state_next = S_SRCH;
                end
            end

            S_DIV:
            begin
                rem_next = div_r2[31:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    route_next = div_r2[31:0];
                    state_next = S_DONE;
                end
            end

            S_SRCH:
            begin
                if (len_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (lo_reg < hi_reg)
                begin
                    mid_next   = LEN_W'(mid_sum);
                    r_raddr    = AW'(mid_sum);
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    r_raddr    = (lo_reg >= len_reg) ? '0 : AW'(lo_reg);
                    state_next = S_SRCH_OUT;
                end
            end

            S_SRCH_CMP:
            begin
                if (ring_rdata[63:32] < h_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end

            S_SRCH_OUT:
            begin
                route_next = ring_rdata[31:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_route_next  = route_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            len_reg       <= '0;
            ring_sel_reg  <= 1'b0;
            acc_reg       <= chsr_pkg::FNV_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            len_reg       <= len_next;
            ring_sel_reg  <= ring_sel_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        off_reg        <= off_next;
        vec_reg        <= vec_next;
        i_reg          <= i_next;
        n_reg          <= n_next;
        v_reg          <= v_next;
        k_reg          <= k_next;
        h_reg          <= h_next;
        gid_reg        <= gid_next;
        w_reg          <= w_next;
        base_reg       <= base_next;
        li_reg         <= li_next;
        ri_reg         <= ri_next;
        le_reg         <= le_next;
        re_reg         <= re_next;
        kk_reg         <= kk_next;
        src_reg        <= src_next;
        lval_reg       <= lval_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        cnt_reg        <= cnt_next;
        stat_reg       <= stat_next;
        route_reg      <= route_next;
        out_status_reg <= out_status_next;
        out_route_reg  <= out_route_next;
    end

endmodule

// File: hw/rtl/consistent_hash_shard_router.sv
// consistent_hash_shard_router: top level; config registers, front queue, back sequencer.
// Depends on chsr_pkg, chsr_front, chsr_back (and chsr_ram through it).
//
//  channel | signals                                                       | handshake
//  --------+---------------------------------------------------------------+------------------
//  in      | command shard_ident go_offline vector_ident key_byte key_last | in_valid/in_stall
//  out     | status routed_shard                                           | out_valid/out_stall
//  cfg     | cfg_index cfg_data                                            | cfg_valid/cfg_ready
//
// Items are worked one at a time; a 2-word queue lets input be taken meanwhile.
// A key byte that is not the last only updates the running hash. A ring lookup is a
// binary search of the ring (a vector is hashed first); a modulo lookup runs the divider.
// A table change scans the table entries, then rebuilds the ring: it generates the nodes,
// then merge-sorts them in passes (log2 of ring length, rounded up).
// Reset needs no clearing pass; results wait in the output register under stall.
`timescale 1ns / 1ps

module consistent_hash_shard_router #(
    parameter int MAX_SHARD_ENTRIES = 64,
    parameter int MAX_VNODES        = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] shard_ident,
    input  logic        go_offline,
    input  logic [63:0] vector_ident,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] routed_shard,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    chsr_pkg::cfg_t  cfg_reg, cfg_next;
    chsr_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                chsr_pkg::REG_USE_MODULO:    cfg_next.use_modulo       = cfg_data[0];
                chsr_pkg::REG_MODULO_SHARDS: cfg_next.modulo_shards    = cfg_data;
                chsr_pkg::REG_VNODES:        cfg_next.vnodes_per_shard = cfg_data[8:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_modulo       <= 1'b0;
            cfg_reg.modulo_shards    <= chsr_pkg::RESET_MODULO;
            cfg_reg.vnodes_per_shard <= chsr_pkg::RESET_VNODES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    chsr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .shard_ident  (shard_ident),
        .go_offline   (go_offline),
        .vector_ident (vector_ident),
        .key_byte     (key_byte),
        .key_last     (key_last),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    chsr_back #(
        .MAX_SHARD_ENTRIES (MAX_SHARD_ENTRIES),
        .MAX_VNODES        (MAX_VNODES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .routed_shard (routed_shard)
    );

endmodule

// File: hw/rtl/chsr_checker.sv
// chsr_checker: port-level assertions for the shard router, bound to the top level.
// Depends on chsr_pkg and consistent_hash_shard_router.
`timescale 1ns / 1ps

module chsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] routed_shard,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(routed_shard))
        else $error("output word changed under stall");

    // failed table changes never carry a shard
    a_fail_no_shard: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != chsr_pkg::ST_OK) |-> (routed_shard == 32'd0))
        else $error("error status with nonzero shard");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind consistent_hash_shard_router chsr_checker u_chsr_checker (.*);

// File: tb/consistent_hash_shard_router_tb.sv
// consistent_hash_shard_router_tb: self-checking bench for the shard router.
// Depends on chsr_pkg and consistent_hash_shard_router; a queue-fed driver, a
// stalling monitor and a built-in ring predictor check every result word.
`timescale 1ns / 1ps

module consistent_hash_shard_router_tb;

    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;
    localparam int TABLE_MAX  = 64;
    localparam int VNODE_CAP  = 256;
    localparam int IDLE_LIMIT = 400000;
    localparam int POOL_SIZE  = 12;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] sid;
        logic        off;
        logic [63:0] vec;
        logic [7:0]  kb;
        logic        last;
    } req_t;

    typedef struct {
        logic [1:0]  st;
        logic [31:0] shard;
    } route_t;

    typedef struct {
        logic [31:0] id;
        bit          offline;
    } shard_ent_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [31:0] shard_ident;
    logic        go_offline;
    logic [63:0] vector_ident;
    logic [7:0]  key_byte;
    logic        key_last;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] routed_shard;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    consistent_hash_shard_router i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .shard_ident(shard_ident), .go_offline(go_offline),
        .vector_ident(vector_ident), .key_byte(key_byte), .key_last(key_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .routed_shard(routed_shard),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    bit          mdl_use_modulo;
    logic [31:0] mdl_modulo;
    logic [8:0]  mdl_vnodes;
    shard_ent_t  shard_tab[$];
    logic [63:0] ring[$];
    logic [31:0] key_acc;

    req_t   pending[$];
    route_t routes_due[$];
    int     errors;
    int     items_taken;
    int     results_seen;
    bit     no_gaps;
    logic [31:0] id_pool[POOL_SIZE];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * chsr_pkg::FNV_PRIME;
    endfunction

    function automatic logic [31:0] fnv_word(logic [63:0] v);
        logic [31:0] h;
        h = chsr_pkg::FNV_BASIS;
        for (int k = 0; k < 8; k++)
            h = fnv_mix(h, v[8*k +: 8]);
        return h;
    endfunction

    task automatic regen_ring();
        int vn;
        vn = (mdl_vnodes > VNODE_CAP) ? VNODE_CAP : int'(mdl_vnodes);
        ring.delete();
        foreach (shard_tab[i])
            if (!shard_tab[i].offline)
                for (int v = 0; v < vn; v++)
                    ring.push_back({fnv_word({shard_tab[i].id, 32'(v)}), shard_tab[i].id});
        ring.sort();
    endtask

    function automatic logic [31:0] ring_pick(logic [31:0] h);
        if (ring.size() == 0)
            return 32'd0;
        foreach (ring[i])
            if (ring[i][63:32] >= h)
                return ring[i][31:0];
        return ring[0][31:0];
    endfunction

    function automatic int shard_pos(logic [31:0] id);
        foreach (shard_tab[i])
            if (shard_tab[i].id == id)
                return i;
        return -1;
    endfunction

    task automatic route_word(req_t r);
        route_t res;
        int     pos;
        res.st = chsr_pkg::ST_OK;
        res.shard = 32'd0;
        case (r.cmd)
            chsr_pkg::CMD_ADD:
            begin
                if (shard_pos(r.sid) >= 0)
                    res.st = chsr_pkg::ST_DUPLICATE;
                else if (shard_tab.size() >= TABLE_MAX)
                    res.st = chsr_pkg::ST_FULL;
                else
                begin
                    shard_tab.push_back('{r.sid, 1'b0});
                    regen_ring();
                end
            end
            chsr_pkg::CMD_REMOVE:
            begin
                pos = shard_pos(r.sid);
                if (pos < 0)
                    res.st = chsr_pkg::ST_NOT_FOUND;
                else
                begin
                    shard_tab.delete(pos);
                    regen_ring();
                end
            end
            chsr_pkg::CMD_SET_STATE:
            begin
                pos = shard_pos(r.sid);
                if (pos < 0)
                    res.st = chsr_pkg::ST_NOT_FOUND;
                else
                begin
                    shard_tab[pos].offline = r.off;
                    regen_ring();
                end
            end
            chsr_pkg::CMD_VECTOR:
            begin
                if (mdl_use_modulo)
                begin
                    if (mdl_modulo != 0)
                        res.shard = 32'(r.vec % {32'd0, mdl_modulo});
                end
                else
                    res.shard = ring_pick(fnv_word(r.vec));
            end
            chsr_pkg::CMD_KEY_BYTE:
            begin
                key_acc = fnv_mix(key_acc, r.kb);
                if (!r.last)
                    return;
                res.shard = ring_pick(key_acc);
                key_acc = chsr_pkg::FNV_BASIS;
            end
            default:
                return;
        endcase
        routes_due.push_back(res);
    endtask

    function automatic int gap_len();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(99);
        if (p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // driver: one NBA per signal per edge
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        bit   taken;
        req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                route_word(pending.pop_front());
                items_taken++;
            end
            if (!in_valid || taken)
            begin
                if (in_gap > 0 || pending.size() == 0)
                begin
                    if (in_gap > 0)
                        in_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = pending[0];
                    command <= nxt.cmd;
                    shard_ident <= nxt.sid;
                    go_offline <= nxt.off;
                    vector_ident <= nxt.vec;
                    key_byte <= nxt.kb;
                    key_last <= nxt.last;
                    in_valid <= 1'b1;
                    in_gap = gap_len();
                end
            end
        end
    end

    // monitor with random stalls and one long hold-off to back the block up
    int  out_gap;
    int  hold_left;
    bit  held_once;
    always @(posedge clk or negedge rst_n)
    begin
        route_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
            hold_left = 0;
            held_once = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (routes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word status=%0d shard=%h",
                             $time, status, routed_shard);
                end
                else
                begin
                    want = routes_due.pop_front();
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (routed_shard !== want.shard)
                    begin
                        errors++;
                        $display("%0t: routed_shard expected %h actual %h",
                                 $time, want.shard, routed_shard);
                    end
                end
            end
            if (!held_once && results_seen >= 150)
            begin
                held_once = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_gap = gap_len();
                out_stall <= (out_gap > 0);
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            chsr_pkg::REG_USE_MODULO:    mdl_use_modulo = val[0];
            chsr_pkg::REG_MODULO_SHARDS: mdl_modulo = val;
            chsr_pkg::REG_VNODES:        mdl_vnodes = val[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_valid || routes_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic req_t blank_req(logic [2:0] cmd);
        req_t r;
        r.cmd = cmd;
        r.sid = $urandom();
        r.off = 1'($urandom_range(1));
        r.vec = {$urandom(), $urandom()};
        r.kb = 8'($urandom_range(255));
        r.last = 1'b1;
        return r;
    endfunction

    task automatic push_op(logic [2:0] cmd, logic [31:0] sid, logic off = 1'b0);
        req_t r;
        r = blank_req(cmd);
        r.sid = sid;
        r.off = off;
        pending.push_back(r);
    endtask

    task automatic push_vec(logic [63:0] v);
        req_t r;
        r = blank_req(chsr_pkg::CMD_VECTOR);
        r.vec = v;
        pending.push_back(r);
    endtask

    task automatic push_key(int len);
        req_t r;
        for (int k = 0; k < len; k++)
        begin
            r = blank_req(chsr_pkg::CMD_KEY_BYTE);
            r.last = (k == len - 1);
            pending.push_back(r);
            if (!r.last && $urandom_range(9) == 0)
                push_vec({$urandom(), $urandom()});
        end
    endtask

    initial
    begin
        int     n_rand;
        int     pick;
        req_t   r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = chsr_pkg::REG_USE_MODULO;
        cfg_data = 32'd0;
        command = chsr_pkg::CMD_ADD;
        shard_ident = 32'd0;
        go_offline = 1'b0;
        vector_ident = 64'd0;
        key_byte = 8'd0;
        key_last = 1'b0;
        errors = 0;
        items_taken = 0;
        results_seen = 0;
        no_gaps = 1'b0;
        mdl_use_modulo = 1'b0;
        mdl_modulo = chsr_pkg::RESET_MODULO;
        mdl_vnodes = chsr_pkg::RESET_VNODES;
        key_acc = chsr_pkg::FNV_BASIS;
        id_pool[0] = 32'd0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = (i < 6) ? 32'(i) : $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty ring, extreme ids, duplicates, missing ids, key stream
        push_vec(64'd0);
        push_key(1);
        push_op(chsr_pkg::CMD_REMOVE, 32'd7);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd7, 1'b1);
        push_op(chsr_pkg::CMD_ADD, 32'd0);
        push_op(chsr_pkg::CMD_ADD, 32'hFFFF_FFFF);
        push_op(chsr_pkg::CMD_ADD, 32'd0);
        push_vec(64'd0);
        push_vec(64'hFFFF_FFFF_FFFF_FFFF);
        r = blank_req(chsr_pkg::CMD_KEY_BYTE);
        r.kb = 8'hFF;
        r.last = 1'b0;
        pending.push_back(r);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b1);
        r.kb = 8'h00;
        pending.push_back(r);
        r.last = 1'b1;
        pending.push_back(r);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b1);
        push_op(chsr_pkg::CMD_SET_STATE, 32'hFFFF_FFFF, 1'b1);
        push_vec(64'h0123_4567_89AB_CDEF);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b0);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b0);
        pending.push_back(blank_req(CMD_BAD_LO));
        pending.push_back(blank_req(CMD_BAD_HI));
        push_key(3);
        push_op(chsr_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
        drain();

        // modulo routing, divisor extremes and zero
        write_reg(chsr_pkg::REG_USE_MODULO, 32'd1);
        foreach (id_pool[i])
        begin
            if (i % 4 == 0)
            begin
                drain();
                write_reg(chsr_pkg::REG_MODULO_SHARDS, (i == 0) ? 32'd0
                          : (i == 4) ? 32'd1 : 32'hFFFF_FFFF);
            end
            push_vec({$urandom(), $urandom()});
            push_vec(64'hFFFF_FFFF_FFFF_FFFF);
        end
        drain();
        write_reg(chsr_pkg::REG_USE_MODULO, 32'd0);

        // node count extremes: zero, saturating, max
        write_reg(chsr_pkg::REG_VNODES, 32'd0);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b0);
        push_vec({$urandom(), $urandom()});
        push_key(2);
        drain();
        write_reg(chsr_pkg::REG_VNODES, 32'h1FF);
        push_op(chsr_pkg::CMD_SET_STATE, 32'd0, 1'b0);
        for (int i = 0; i < 6; i++)
            push_vec({$urandom(), $urandom()});
        drain();
        write_reg(chsr_pkg::REG_VNODES, 32'd256);
        push_op(chsr_pkg::CMD_ADD, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            push_key($urandom_range(4, 1));
        drain();

        // fill the table without nodes, probe full and duplicate, shrink back
        write_reg(chsr_pkg::REG_VNODES, 32'd0);
        for (int i = 0; i < TABLE_MAX; i++)
            push_op(chsr_pkg::CMD_ADD, 32'h8000_0000 + 32'(i));
        push_op(chsr_pkg::CMD_ADD, 32'h7777_7777);
        push_op(chsr_pkg::CMD_ADD, 32'h8000_0000);
        drain();
        write_reg(chsr_pkg::REG_VNODES, 32'd1);
        push_op(chsr_pkg::CMD_SET_STATE, 32'h8000_0005, 1'b1);
        for (int i = 0; i < 8; i++)
            push_vec({$urandom(), $urandom()});
        drain();
        write_reg(chsr_pkg::REG_VNODES, 32'd0);
        for (int i = 0; i < TABLE_MAX; i++)
            push_op(chsr_pkg::CMD_REMOVE, 32'h8000_0000 + 32'(i));
        push_op(chsr_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
        push_op(chsr_pkg::CMD_REMOVE, 32'd0);
        drain();

        // random rounds, each under a fresh setting; counts the words queued
        n_rand = 0;
        for (int round = 0; n_rand < 1230; round++)
        begin
            write_reg(chsr_pkg::REG_USE_MODULO, 32'($urandom_range(3) == 0));
            write_reg(chsr_pkg::REG_MODULO_SHARDS, ($urandom_range(3) == 0) ? $urandom()
                      : $urandom_range(20));
            write_reg(chsr_pkg::REG_VNODES, $urandom_range(8, 1));
            no_gaps = (round % 4 == 3);
            for (int k = 0; k < 60; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    push_op($urandom_range(2) == 0 ? chsr_pkg::CMD_REMOVE
                            : ($urandom_range(1) ? chsr_pkg::CMD_ADD
                               : chsr_pkg::CMD_SET_STATE),
                            ($urandom_range(15) == 0) ? $urandom()
                            : id_pool[$urandom_range(POOL_SIZE - 1)],
                            $urandom_range(2) == 0);
                else if (pick < 50)
                    push_vec({$urandom(), $urandom()});
                else if (pick < 96)
                    push_key($urandom_range(6, 1));
                else
                    pending.push_back(blank_req(3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO))));
            end
            n_rand += pending.size();
            drain();
        end

        $display("covered %0d input words and %0d result words: table edits, full and",
                 items_taken, results_seen);
        $display("missing ids, modulo and ring routing, streamed keys, node count limits");
        if (errors == 0 && routes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
